FILE: rtl/core/tofsig_pkg.sv
// Shared types and constants for the time-of-flight sigma and max-range estimator.
// Used by the estimator top level and its bound checker; no dependencies.
package tofsig_pkg;

	typedef struct packed {
		logic [15:0] spad_count;
		logic [31:0] return_rate;
		logic [31:0] ambient_rate;
		logic [15:0] distance_mm;
	} in_item_t;

	typedef struct packed {
		logic [25:0] sigma;
		logic [15:0] max_range_mm;
	} out_item_t;

	// register indexes of the write port
	localparam logic [2:0] REG_XTALK    = 3'd0;
	localparam logic [2:0] REG_CAL_RATE = 3'd1;
	localparam logic [2:0] REG_CAL_RNG  = 3'd2;
	localparam logic [2:0] REG_PEAK     = 3'd3;
	localparam logic [2:0] REG_INTEG    = 3'd4;

	localparam logic [31:0] ONE_FP        = 32'h0001_0000;
	localparam logic [31:0] SIGMA_MAX     = 32'h028F_87AE;
	localparam logic [31:0] SIGMA_RTN_MAX = 32'h0000_1999;
	localparam logic [31:0] TOF_PER_MM    = 32'h0006_999A;
	localparam logic [31:0] LIGHT_SPEED   = 32'd2997;
	localparam logic [31:0] REF_TIME      = 32'h61A8_0000;
	localparam logic [31:0] VCSEL_WIDTH   = 32'd4700;
	localparam logic [31:0] PULSE_WIDTH   = 32'd800;
	localparam logic [31:0] AMB_WIDTH     = 32'd600;
	localparam logic [31:0] AMB_WIDTH_DM  = 32'd700;
	localparam logic [31:0] SIGMA_LIMIT   = 32'h0000_049C;
	localparam logic [31:0] SIGMA_REF     = 32'h0000_0042;
	localparam logic [31:0] RATE_LIMIT    = 32'h0000_0040;
	localparam logic [31:0] RATIO_MAX     = 32'(64'hF000_0000 / 64'd700);
	localparam logic [31:0] P4_CONST      = 32'((48 * (SIGMA_LIMIT * SIGMA_LIMIT
		- SIGMA_REF * SIGMA_REF) + 32'h2_0000) >> 18);

	localparam logic [31:0] RST_CAL_RNG = 32'd400;
	localparam logic [31:0] RST_INTEG   = 32'd33000;

	// round a 16.16 value to integer
	function automatic logic [31:0] rnd16(input logic [31:0] a);
		logic [31:0] s;
		s = a + 32'h0000_8000;
		return {16'd0, s[31:16]};
	endfunction

	function automatic logic [31:0] rnd8(input logic [31:0] a);
		logic [31:0] s;
		s = a + 32'h0000_0080;
		return {8'd0, s[31:8]};
	endfunction

endpackage

FILE: rtl/core/tof_sigma_and_max_range_estimator.sv
// Time-of-flight sigma and max-range estimator, sequenced over a shared
// multiplier, a radix-2 divider and a bit-by-bit square-root unit. Uses tofsig_pkg.
//
// Usage:
//  Input channel in_valid/in_stall/in_data carries one ranging result. A
//  request is taken when in_valid is high and in_stall is low. in_stall stays
//  high while the sequencer works on an item.
//  Output channel out_valid/out_stall/out_data carries sigma (16.16 mm) and
//  the maximum reliable range (mm). out_data holds while out_stall is high.
//  When the total rate or the event count is zero, only the first divider
//  pass runs; otherwise up to fourteen divider passes and six square roots
//  run, all one after another on the single divider and root unit.
//  Items are worked on one at a time; the next item is taken once the result
//  has moved to the output register, so a waiting result does not block
//  the next computation, only its final hand-off.
//  Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle;
//  write only while idle. Unknown indexes are dropped.
//  Reset (arst_n low): registers return to defaults, channels go idle.
module tof_sigma_and_max_range_estimator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  tofsig_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output tofsig_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_wdata
);

	typedef enum logic [5:0] {
		ST_IDLE, ST_WAIT, ST_XT, ST_TOT, ST_DEN, ST_AM, ST_RATIO, ST_EV, ST_CHK,
		ST_TOF, ST_XTC, ST_PW0, ST_PW1, ST_S1, ST_S1B, ST_S2, ST_S2B, ST_ROOT,
		ST_EVR, ST_RTN0, ST_RTN1, ST_RTN2, ST_REF0, ST_REF1, ST_SG0, ST_SG1,
		ST_SG2, ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_R6, ST_R7, ST_R8,
		ST_R9, ST_R10, ST_R11, ST_R12, ST_R13, ST_R14, ST_R15, ST_EMIT
	} state_t;

	state_t state_q, nxt_q;

	logic [15:0] xtr_q, calrng_q;
	logic [31:0] calsig_q, peak_q, integ_q;

	logic [15:0] spad_q, dist_q;
	logic [31:0] rr_q, amb_q;
	logic [31:0] xt_q, tot_q, den_q, ratio_q, ev_q, a_q, pw_q, s1_q, rtn_q;
	logic [31:0] s0_q, p1_q, n_q, p3_q, sigma_q;
	logic [15:0] dark_q, range_q;

	// divider
	logic        dv_busy_q;
	logic [5:0]  dv_cnt_q;
	logic [31:0] dv_rem_q, dv_quo_q, dv_d_q;
	logic [32:0] dv_rs;
	// square root
	logic        sq_busy_q;
	logic [4:0]  sq_cnt_q;
	logic [31:0] sq_v_q, sq_r_q, sq_b_q;
	logic [32:0] sq_t;

	logic [31:0] mul_a, mul_b, mul_p;
	logic [63:0] mul_full;
	logic [31:0] tot_rnd;

	tofsig_pkg::out_item_t out_q;
	logic out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign tot_rnd = tofsig_pkg::rnd8(tot_q);
	assign dv_rs   = {dv_rem_q, dv_quo_q[31]};
	assign sq_t    = {1'b0, sq_r_q} + {1'b0, sq_b_q};

	// shared multiplier operand select
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			ST_XT:   begin mul_a = {16'd0, spad_q}; mul_b = {16'd0, xtr_q}; end
			ST_DEN:  begin mul_a = tot_q;  mul_b = 32'd1000; end
			ST_AM:   begin mul_a = amb_q;  mul_b = 32'd1000; end
			ST_EV:   begin mul_a = tot_rnd; mul_b = peak_q; end
			ST_TOF:  begin mul_a = {16'd0, dist_q}; mul_b = tofsig_pkg::TOF_PER_MM; end
			ST_PW0:  begin
				mul_a = a_q;
				mul_b = tofsig_pkg::ONE_FP - (dv_quo_q << 8);
			end
			ST_PW1:  begin mul_a = pw_q >> 1; mul_b = pw_q >> 1; end
			ST_S1:   begin mul_a = pw_q; mul_b = tofsig_pkg::PULSE_WIDTH; end
			ST_S1B:  begin mul_a = a_q; mul_b = a_q; end
			ST_S2:   begin mul_a = ratio_q; mul_b = tofsig_pkg::AMB_WIDTH; end
			ST_S2B:  begin mul_a = a_q; mul_b = a_q; end
			ST_EVR:  begin mul_a = ev_q; mul_b = 32'd12; end
			ST_RTN1: begin mul_a = dv_quo_q; mul_b = tofsig_pkg::LIGHT_SPEED; end
			ST_SG0:  begin mul_a = dv_quo_q; mul_b = dv_quo_q; end
			ST_SG1:  begin mul_a = rtn_q; mul_b = rtn_q; end
			ST_SG2:  begin mul_a = sq_r_q; mul_b = 32'd1000; end
			ST_R0:   begin mul_a = calsig_q; mul_b = {16'd0, calrng_q}; end
			ST_R1:   begin mul_a = a_q; mul_b = {16'd0, calrng_q}; end
			ST_R2:   begin mul_a = pw_q; mul_b = tofsig_pkg::PULSE_WIDTH; end
			ST_R3:   begin mul_a = a_q; mul_b = a_q; end
			ST_R4:   begin mul_a = ratio_q; mul_b = tofsig_pkg::AMB_WIDTH_DM; end
			ST_R5:   begin mul_a = a_q; mul_b = a_q; end
			ST_R8:   begin mul_a = 32'd3; mul_b = dv_quo_q; end
			ST_R9:   begin mul_a = a_q; mul_b = a_q; end
			ST_R10:  begin mul_a = n_q; mul_b = p3_q; end
			default: begin mul_a = 32'd0; mul_b = 32'd0; end
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign mul_p    = mul_full[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nxt_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
			dv_busy_q   <= 1'b0;
			sq_busy_q   <= 1'b0;
			xtr_q       <= 16'd0;
			calsig_q    <= 32'd0;
			calrng_q    <= tofsig_pkg::RST_CAL_RNG[15:0];
			peak_q      <= 32'd0;
			integ_q     <= tofsig_pkg::RST_INTEG;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tofsig_pkg::REG_XTALK:    xtr_q    <= cfg_wdata[15:0];
					tofsig_pkg::REG_CAL_RATE: calsig_q <= cfg_wdata;
					tofsig_pkg::REG_CAL_RNG:  calrng_q <= cfg_wdata[15:0];
					tofsig_pkg::REG_PEAK:     peak_q   <= cfg_wdata;
					tofsig_pkg::REG_INTEG:    integ_q  <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall && state_q != ST_EMIT) out_valid_q <= 1'b0;

			// restoring divider, one quotient bit per cycle
			if (dv_busy_q) begin
				if (dv_rs >= {1'b0, dv_d_q}) begin
					dv_rem_q <= 32'(dv_rs - {1'b0, dv_d_q});
					dv_quo_q <= {dv_quo_q[30:0], 1'b1};
				end else begin
					dv_rem_q <= dv_rs[31:0];
					dv_quo_q <= {dv_quo_q[30:0], 1'b0};
				end
				dv_cnt_q  <= dv_cnt_q - 6'd1;
				dv_busy_q <= (dv_cnt_q != 6'd1);
			end

			// square root, one result bit per cycle
			if (sq_busy_q) begin
				if ({1'b0, sq_v_q} >= sq_t) begin
					sq_v_q <= 32'({1'b0, sq_v_q} - sq_t);
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q    <= sq_b_q >> 2;
				sq_cnt_q  <= sq_cnt_q - 5'd1;
				sq_busy_q <= (sq_cnt_q != 5'd1);
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						spad_q  <= in_data.spad_count;
						rr_q    <= in_data.return_rate;
						amb_q   <= in_data.ambient_rate;
						dist_q  <= in_data.distance_mm;
						state_q <= ST_XT;
					end
				end
				ST_WAIT: begin
					if (!dv_busy_q && !sq_busy_q) state_q <= nxt_q;
				end
				ST_XT: begin
					xt_q    <= tofsig_pkg::rnd8(mul_p);
					state_q <= ST_TOT;
				end
				ST_TOT: begin
					tot_q   <= rr_q + xt_q;
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					den_q   <= tofsig_pkg::rnd16(mul_p);
					state_q <= ST_AM;
				end
				ST_AM: begin
					// zero denominator gives all ones, clipped below
					dv_quo_q <= mul_p; dv_d_q <= den_q; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_RATIO; state_q <= ST_WAIT;
				end
				ST_RATIO: begin
					ratio_q <= (dv_quo_q > tofsig_pkg::RATIO_MAX) ?
						tofsig_pkg::RATIO_MAX : dv_quo_q;
					state_q <= ST_EV;
				end
				ST_EV: begin
					ev_q    <= tofsig_pkg::rnd8(mul_p);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (tot_q == 32'd0 || ev_q == 32'd0) begin
						sigma_q <= tofsig_pkg::SIGMA_MAX;
						range_q <= 16'd0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_TOF;
					end
				end
				ST_TOF: begin
					dv_quo_q <= mul_p; dv_d_q <= tofsig_pkg::VCSEL_WIDTH; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_XTC; state_q <= ST_WAIT;
				end
				ST_XTC: begin
					a_q <= dv_quo_q;
					dv_quo_q <= (rr_q - xt_q) << 8; dv_d_q <= tot_q; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_PW0; state_q <= ST_WAIT;
				end
				ST_PW0: begin
					pw_q    <= tofsig_pkg::ONE_FP + tofsig_pkg::rnd16(mul_p);
					state_q <= ST_PW1;
				end
				ST_PW1: begin
					pw_q    <= {14'd0, 18'((mul_p + 32'h2000) >> 14)};
					state_q <= ST_S1;
				end
				ST_S1: begin
					a_q     <= tofsig_pkg::rnd16(mul_p);
					state_q <= ST_S1B;
				end
				ST_S1B: begin
					s1_q    <= mul_p;
					state_q <= ST_S2;
				end
				ST_S2: begin
					a_q     <= tofsig_pkg::rnd16(mul_p);
					state_q <= ST_S2B;
				end
				ST_S2B: begin
					sq_v_q <= s1_q + mul_p; sq_r_q <= 32'd0; sq_b_q <= 32'h4000_0000;
					sq_cnt_q <= 5'd16; sq_busy_q <= 1'b1;
					nxt_q <= ST_ROOT; state_q <= ST_WAIT;
				end
				ST_ROOT: begin
					dv_quo_q <= sq_r_q << 16; dv_d_q <= 32'd100; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_EVR; state_q <= ST_WAIT;
				end
				ST_EVR: begin
					a_q <= dv_quo_q;
					sq_v_q <= mul_p; sq_r_q <= 32'd0; sq_b_q <= 32'h4000_0000;
					sq_cnt_q <= 5'd16; sq_busy_q <= 1'b1;
					nxt_q <= ST_RTN0; state_q <= ST_WAIT;
				end
				ST_RTN0: begin
					dv_quo_q <= a_q; dv_d_q <= sq_r_q << 1; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_RTN1; state_q <= ST_WAIT;
				end
				ST_RTN1: begin
					dv_quo_q <= mul_p; dv_d_q <= 32'd10000; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_RTN2; state_q <= ST_WAIT;
				end
				ST_RTN2: begin
					rtn_q <= (dv_quo_q > tofsig_pkg::SIGMA_RTN_MAX) ?
						tofsig_pkg::SIGMA_RTN_MAX : dv_quo_q;
					dv_quo_q <= tofsig_pkg::REF_TIME; dv_d_q <= integ_q; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_REF0; state_q <= ST_WAIT;
				end
				ST_REF0: begin
					sq_v_q <= dv_quo_q; sq_r_q <= 32'd0; sq_b_q <= 32'h4000_0000;
					sq_cnt_q <= 5'd16; sq_busy_q <= 1'b1;
					nxt_q <= ST_REF1; state_q <= ST_WAIT;
				end
				ST_REF1: begin
					dv_quo_q <= sq_r_q << 8; dv_d_q <= 32'd1000; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_SG0; state_q <= ST_WAIT;
				end
				ST_SG0: begin
					a_q     <= mul_p;
					state_q <= ST_SG1;
				end
				ST_SG1: begin
					sq_v_q <= a_q + mul_p; sq_r_q <= 32'd0; sq_b_q <= 32'h4000_0000;
					sq_cnt_q <= 5'd16; sq_busy_q <= 1'b1;
					nxt_q <= ST_SG2; state_q <= ST_WAIT;
				end
				ST_SG2: begin
					sigma_q <= (mul_p > tofsig_pkg::SIGMA_MAX) ? tofsig_pkg::SIGMA_MAX : mul_p;
					state_q <= ST_R0;
				end
				ST_R0: begin
					a_q     <= tofsig_pkg::rnd8(mul_p);
					state_q <= ST_R1;
				end
				ST_R1: begin
					s0_q    <= mul_p;
					state_q <= ST_R2;
				end
				ST_R2: begin
					a_q     <= tofsig_pkg::rnd16(mul_p);
					state_q <= ST_R3;
				end
				ST_R3: begin
					p1_q    <= mul_p;
					state_q <= ST_R4;
				end
				ST_R4: begin
					a_q     <= tofsig_pkg::rnd16(mul_p);
					state_q <= ST_R5;
				end
				ST_R5: begin
					dv_quo_q <= p1_q + mul_p; dv_d_q <= peak_q; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_R6; state_q <= ST_WAIT;
				end
				ST_R6: begin
					dv_quo_q <= dv_quo_q << 14; dv_d_q <= tofsig_pkg::P4_CONST;
					dv_rem_q <= 32'd0; dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_R7; state_q <= ST_WAIT;
				end
				ST_R7: begin
					// no return rate: rate-ratio term is zero, so the need is zero
					if (rr_q == 32'd0) begin
						n_q     <= 32'd0;
						state_q <= ST_R12;
					end else begin
						n_q <= dv_quo_q;
						dv_quo_q <= tot_q << 10; dv_d_q <= rr_q; dv_rem_q <= 32'd0;
						dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
						nxt_q <= ST_R8; state_q <= ST_WAIT;
					end
				end
				ST_R8: begin
					a_q     <= mul_p;
					state_q <= ST_R9;
				end
				ST_R9: begin
					p3_q    <= tofsig_pkg::rnd16(mul_p);
					state_q <= ST_R10;
				end
				ST_R10: begin
					dv_quo_q <= mul_p; dv_d_q <= 32'd1000; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_R11; state_q <= ST_WAIT;
				end
				ST_R11: begin
					dv_quo_q <= dv_quo_q << 4; dv_d_q <= 32'd1000; dv_rem_q <= 32'd0;
					dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
					nxt_q <= ST_R12; state_q <= ST_WAIT;
				end
				ST_R12: begin
					if (rr_q != 32'd0) n_q <= dv_quo_q;
					sq_v_q <= s0_q >> 6; sq_r_q <= 32'd0; sq_b_q <= 32'h4000_0000;
					sq_cnt_q <= 5'd16; sq_busy_q <= 1'b1;
					nxt_q <= ST_R13; state_q <= ST_WAIT;
				end
				ST_R13: begin
					dark_q <= sq_r_q[15:0];
					if (n_q == 32'd0) begin
						range_q <= 16'd0;
						state_q <= ST_EMIT;
					end else begin
						dv_quo_q <= s0_q; dv_d_q <= n_q; dv_rem_q <= 32'd0;
						dv_cnt_q <= 6'd32; dv_busy_q <= 1'b1;
						nxt_q <= ST_R14; state_q <= ST_WAIT;
					end
				end
				ST_R14: begin
					sq_v_q <= dv_quo_q; sq_r_q <= 32'd0; sq_b_q <= 32'h4000_0000;
					sq_cnt_q <= 5'd16; sq_busy_q <= 1'b1;
					nxt_q <= ST_R15; state_q <= ST_WAIT;
				end
				ST_R15: begin
					range_q <= (dark_q < sq_r_q[15:0]) ? dark_q : sq_r_q[15:0];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_q.sigma        <= sigma_q[25:0];
						out_q.max_range_mm <= range_q;
						out_valid_q        <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/tofsig_checker.sv
// Port-level checker for the sigma and max-range estimator, bound to the top level.
// Uses tofsig_pkg for the payload types.
module tofsig_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input tofsig_pkg::out_item_t out_data
);

	// a taken request keeps the input closed while it is worked on
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after a request");

	// no result in the cycle right after a request unless one was already waiting
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |=> !out_valid)
		else $error("result appeared without computation");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

	a_sigma_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({6'd0, out_data.sigma} <= tofsig_pkg::SIGMA_MAX))
		else $error("sigma above clip");

endmodule

bind tof_sigma_and_max_range_estimator tofsig_checker u_tofsig_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

FILE: tb/tb.sv
// Self-checking bench for tof_sigma_and_max_range_estimator: random ranging results
// against an in-bench fixed-point predictor across several register settings.
// Depends on tofsig_pkg and the estimator RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RATIO_CAP = 32'hF000_0000 / 32'd700;
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 1000;

	class sigma_scoreboard;
		int unsigned xtalk, cal_rate, cal_rng, peak_dur, integ;
		tofsig_pkg::out_item_t pending_results[$];
		int errors, checked;

		function new();
			xtalk = 0; cal_rate = 0; cal_rng = 400; peak_dur = 0; integ = 33000;
			errors = 0; checked = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				tofsig_pkg::REG_XTALK: xtalk = {16'd0, val[15:0]};
				tofsig_pkg::REG_CAL_RATE: cal_rate = val;
				tofsig_pkg::REG_CAL_RNG: cal_rng = {16'd0, val[15:0]};
				tofsig_pkg::REG_PEAK: peak_dur = val;
				tofsig_pkg::REG_INTEG: integ = val;
				default: ;
			endcase
		endfunction

		static function int unsigned div0(int unsigned n, int unsigned d);
			return (d != 0) ? n / d : 32'hFFFF_FFFF;
		endfunction

		static function int unsigned root32(int unsigned v);
			int unsigned r, b;
			r = 0;
			b = 32'h4000_0000;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		static function int unsigned round16(int unsigned a);
			int unsigned s;
			s = a + 32'h8000;
			return s >> 16;
		endfunction

		function int unsigned range_cap(int unsigned ret, int unsigned tot, int unsigned pw,
				int unsigned ratio, int unsigned pk);
			int unsigned s0, p1, p2, p3, p4, need, dark, amb, t;
			s0 = cal_rate * cal_rng;
			s0 = (s0 + 32'h80) >> 8;
			s0 = s0 * cal_rng;
			t = round16(pw * 800); p1 = t * t;
			t = round16(ratio * 700); p2 = t * t;
			if (ret == 0) begin
				p3 = 0;
			end else begin
				p3 = div0(tot << 10, ret);
				t = 3 * p3;
				p3 = round16(t * t);
			end
			p4 = 48 * (32'h49C * 32'h49C - 32'h42 * 32'h42);
			p4 = (p4 + 32'h2_0000) >> 18;
			need = div0(p1 + p2, pk);
			need = need << 14;
			need = div0(need, p4);
			need = need * p3;
			need = div0(need, 1000);
			need = div0(need << 4, 1000);
			dark = root32(div0(s0, 32'h40)) & 32'hFFFF;
			amb = (need != 0) ? (root32(div0(s0, need)) & 32'hFFFF) : 0;
			return (dark < amb) ? dark : amb;
		endfunction

		function void note_request(tofsig_pkg::in_item_t it);
			int unsigned spad, ret, ambr, dist_mm, xt, tot, den, ratio, events;
			int unsigned tof, d1, xtc, pw, s1, s2, root, rtn, refv, sig, t;
			tofsig_pkg::out_item_t res;
			spad = {16'd0, it.spad_count}; ret = it.return_rate;
			ambr = it.ambient_rate; dist_mm = {16'd0, it.distance_mm};
			xt = spad * xtalk;
			xt = (xt + 32'h80) >> 8;
			tot = ret + xt;
			den = round16(tot * 1000);
			ratio = (den != 0) ? (ambr * 1000) / den : RATIO_CAP;
			if (ratio > RATIO_CAP) ratio = RATIO_CAP;
			events = ((tot + 32'h80) >> 8) * peak_dur;
			events = (events + 32'h80) >> 8;
			if (tot == 0 || events == 0) begin
				res.sigma = 26'h28F87AE;
				res.max_range_mm = 16'd0;
			end else begin
				tof = dist_mm * 32'h0006_999A;
				d1 = (ret - xt) << 8;
				xtc = (d1 / tot) << 8;
				pw = (tof / 4700) * (32'h1_0000 - xtc);
				pw = 32'h1_0000 + round16(pw);
				t = pw >> 1; pw = t * t;
				pw = (pw + 32'h2000) >> 14;
				t = round16(pw * 800); s1 = t * t;
				t = round16(ratio * 600); s2 = t * t;
				root = root32(s1 + s2) << 16;
				rtn = (root / 100) / (2 * root32(events * 12));
				rtn = (rtn * 2997) / 10000;
				if (rtn > 32'h1999) rtn = 32'h1999;
				refv = root32(div0(32'h61A8_0000, integ));
				refv = (refv << 8) / 1000;
				sig = root32(rtn * rtn + refv * refv) * 1000;
				if (sig > 32'h028F_87AE) sig = 32'h028F_87AE;
				res.sigma = sig[25:0];
				res.max_range_mm = 16'(range_cap(ret, tot, pw, ratio, peak_dur));
			end
			pending_results.push_back(res);
		endfunction

		function void check_result(tofsig_pkg::out_item_t got);
			tofsig_pkg::out_item_t exp_res;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: sigma %h range %0d",
					got.sigma, got.max_range_mm);
				errors++;
				return;
			end
			exp_res = pending_results.pop_front();
			checked++;
			if (got.sigma !== exp_res.sigma) begin
				$error("sigma: expected %h, got %h", exp_res.sigma, got.sigma);
				errors++;
			end
			if (got.max_range_mm !== exp_res.max_range_mm) begin
				$error("max_range_mm: expected %0d, got %0d",
					exp_res.max_range_mm, got.max_range_mm);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	tofsig_pkg::in_item_t in_data;
	tofsig_pkg::out_item_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_wdata;

	sigma_scoreboard sb;
	int idle_cycles;
	int sent;

	tof_sigma_and_max_range_estimator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_valid && !in_stall) sb.note_request(in_data);
			if (out_valid && !out_stall) sb.check_result(out_data);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// receiver: short stalls mostly, a few long ones, and free-running stretches
	initial begin
		int dur;
		logic val;
		@(posedge arst_n);
		forever begin
			val = $urandom_range(0, 1);
			if (val)
				dur = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 300)
					: $urandom_range(1, 4);
			else
				dur = $urandom_range(1, 200);
			repeat (dur) begin
				@(posedge clk);
				out_stall <= val;
			end
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
		return $urandom_range(1, 4);
	endfunction

	task automatic send_request(tofsig_pkg::in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// settle: drop valid, wait for every expected result, then for any work still in flight
	task automatic settle();
		@(posedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(logic [31:0] xt, logic [31:0] cr, logic [31:0] rng,
			logic [31:0] pk, logic [31:0] ig);
		write_reg(tofsig_pkg::REG_XTALK, xt);
		write_reg(tofsig_pkg::REG_CAL_RATE, cr);
		write_reg(tofsig_pkg::REG_CAL_RNG, rng);
		write_reg(tofsig_pkg::REG_PEAK, pk);
		write_reg(tofsig_pkg::REG_INTEG, ig);
		write_reg(logic'($urandom_range(0, 1)) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
	endtask

	function automatic tofsig_pkg::in_item_t mk(logic [15:0] spad, logic [31:0] ret,
			logic [31:0] amb, logic [15:0] dmm);
		tofsig_pkg::in_item_t it;
		it.spad_count = spad; it.return_rate = ret;
		it.ambient_rate = amb; it.distance_mm = dmm;
		return it;
	endfunction

	function automatic tofsig_pkg::in_item_t rand_request();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2)
			return mk(16'($urandom()), $urandom(), $urandom(), 16'($urandom()));
		if (sel == 2)
			return mk(16'($urandom_range(0, 16'h4000)), 32'd0,
				$urandom_range(0, 32'h0020_0000), 16'($urandom_range(0, 4000)));
		return mk(16'($urandom_range(0, 16'h4000)), $urandom_range(1, 32'h0050_0000),
			$urandom_range(0, 32'h0020_0000), 16'($urandom_range(0, 4000)));
	endfunction

	initial begin
		int phase;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		idle_cycles = 0;
		sent = 0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a few requests on reset defaults first
		send_request(mk(16'h0800, 32'h0004_0000, 32'h0000_8000, 16'd300));
		send_request(mk(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
		settle();

		load_regs(32'h10, 32'h0014_0000, 32'd400, 32'd2000, 32'd33000);
		send_request(mk(16'd0, 32'd0, 32'd0, 16'd0));
		send_request(mk(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
		send_request(mk(16'h0800, 32'd0, 32'h0001_0000, 16'd500));
		send_request(mk(16'd0, 32'd1, 32'h0001_0000, 16'd100));
		send_request(mk(16'd0, 32'd20, 32'hFFFF_FFFF, 16'd100));
		send_request(mk(16'h0A00, 32'h0010_0000, 32'd0, 16'd0));
		send_request(mk(16'h0A00, 32'h0010_0000, 32'hFFFF_FFFF, 16'd1000));
		send_request(mk(16'h0A00, 32'h0010_0000, 32'h0002_0000, 16'hFFFF));
		send_request(mk(16'hFFFF, 32'h0000_1000, 32'h0002_0000, 16'd800));
		send_request(mk(16'h0100, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000));
		send_request(mk(16'h0400, 32'h0001_0000, 32'h0000_4000, 16'd50));
		send_request(mk(16'h2000, 32'h0300_0000, 32'h0010_0000, 16'd2000));
		send_request(mk(16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA));
		send_request(mk(16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555));
		send_request(mk(16'h0001, 32'h0000_0100, 32'h0000_0001, 16'd1));

		for (phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				0: load_regs(32'h10, 32'h0014_0000, 32'd400, 32'd2000, 32'd33000);
				1: load_regs(0, 0, 0, 32'd1, 32'd1);
				2: load_regs(32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				3: load_regs(32'h40, 32'h0020_0000, 32'd600, 32'd0, 32'd0);
				4: load_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
				default: load_regs($urandom_range(0, 32'h100), $urandom_range(0, 32'h0100_0000),
					$urandom_range(100, 1000), $urandom_range(100, 50000), 32'd0);
			endcase
			if (phase == 3)
				send_request(mk(16'h0A00, 32'h0010_0000, 32'h0002_0000, 16'd600));
			repeat (195) send_request(rand_request());
		end

		settle();
		$display("covered %0d requests and %0d checked results over six register settings",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

FILE: sim.f
rtl/core/tofsig_pkg.sv
rtl/core/tof_sigma_and_max_range_estimator.sv
rtl/core/tofsig_checker.sv
tb/tb.sv
